>>> sv/sliding_window_sigma_outlier_gate_top_assert.svh
`ifndef SLIDING_WINDOW_SIGMA_OUTLIER_GATE_TOP_ASSERT_SVH
`define SLIDING_WINDOW_SIGMA_OUTLIER_GATE_TOP_ASSERT_SVH

// same-cycle and next-cycle implication checks on clk, off while arst_n is low
`ifndef SYNTHESIS
`define SWSOG_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swsog same-cycle check failed");
`define SWSOG_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swsog next-cycle check failed");
`else
`define SWSOG_ASSERT_IMP(lbl, ante, cons)
`define SWSOG_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> sv/swsog_pkg.sv
`default_nettype none

package swsog_pkg;

	localparam int WINDOW_DEPTH = 20;
	localparam int SAMPLE_BITS  = 32;
	localparam int MULT_BITS    = 8;

	localparam int IDX_W   = $clog2(WINDOW_DEPTH);
	localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
	localparam int REM_W   = $clog2(WINDOW_DEPTH);
	localparam int SUM_W   = SAMPLE_BITS + IDX_W;
	localparam int MAG_W   = SAMPLE_BITS + 1;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int ACC_W   = SQ_W + IDX_W;
	localparam int DIGIT_W = 4;
	localparam int DIV_DIGITS  = (ACC_W + DIGIT_W - 1) / DIGIT_W;
	localparam int DIV_W       = DIV_DIGITS * DIGIT_W;
	localparam int MEAN_DIGITS = (SUM_W + DIGIT_W - 1) / DIGIT_W;
	localparam int MEAN_SHIFT  = DIV_W - MEAN_DIGITS * DIGIT_W;
	localparam int ROOT_W  = 2 * SAMPLE_BITS;
	localparam int DEV_W   = SAMPLE_BITS;
	localparam int SPAN_W  = MULT_BITS + DEV_W;
	localparam int BOUND_W = SPAN_W + 2;
	localparam int DCNT_W  = $clog2(DIV_DIGITS);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [DEV_W-1:0] dev_t;
	typedef logic [MULT_BITS-1:0] mult_t;

	localparam mult_t MULT_RESET = mult_t'(8);

	// one radix-16 digit of a restoring division by the window depth
	function automatic logic [REM_W+DIGIT_W-1:0] div_digit(
		input logic [REM_W-1:0]   rem,
		input logic [DIGIT_W-1:0] dig
	);
		logic [REM_W:0]     t;
		logic [REM_W-1:0]   r;
		logic [DIGIT_W-1:0] q;
		r = rem;
		q = '0;
		for (int i = DIGIT_W - 1; i >= 0; i--) begin
			t = {r, dig[i]};
			if (t >= (REM_W+1)'(WINDOW_DEPTH)) begin
				t    = t - (REM_W+1)'(WINDOW_DEPTH);
				q[i] = 1'b1;
			end
			r = t[REM_W-1:0];
		end
		return {r, q};
	endfunction

endpackage

`default_nettype wire

>>> sv/swsog_if.sv
`default_nettype none

interface swsog_sample_if;
	import swsog_pkg::*;
	logic    valid;
	logic    ready;
	sample_t sample;
	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface swsog_result_if;
	import swsog_pkg::*;
	logic    valid;
	logic    ready;
	logic    accepted;
	logic    window_was_full;
	sample_t window_mean;
	dev_t    window_deviation;
	modport source (output valid, output accepted, output window_was_full,
		output window_mean, output window_deviation, input ready);
	modport sink (input valid, input accepted, input window_was_full,
		input window_mean, input window_deviation, output ready);
endinterface

`default_nettype wire

>>> sv/sliding_window_sigma_outlier_gate_top.sv
// While the window fills: the result is shown in the cycle after the transfer.
// Once full: mean division, squared-difference pass, variance division, square root, then
// bound and check; a new sample is taken only after each result has been taken.
// Both divisions share one radix-16 divide-by-depth step; the root resolves one bit a cycle.
// arst_n clears the sequencer, fill count, oldest pointer and running sum; multiplier resets to 8.
// Ring contents are not cleared; entries are read only after all have been written.
`default_nettype none

`include "sliding_window_sigma_outlier_gate_top_assert.svh"

module sliding_window_sigma_outlier_gate_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  swsog_pkg::mult_t      cfg_wdata,
	swsog_sample_if.sink          samples,
	swsog_result_if.source        results
);
	import swsog_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_MEAN  = 8'b0000_0010,
		ST_VAR   = 8'b0000_0100,
		ST_VDIV  = 8'b0000_1000,
		ST_SQRT  = 8'b0001_0000,
		ST_SPAN  = 8'b0010_0000,
		ST_CHECK = 8'b0100_0000,
		ST_OUT   = 8'b1000_0000
	} state_t;

	state_t                   state_q;
	mult_t                    mult_q;
	logic [CNT_W-1:0]         fill_q;
	logic [IDX_W-1:0]         oldest_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic                     vld_s1, vld_s2, vld_s3;

	sample_t                  sample_ring [WINDOW_DEPTH];
	sample_t                  ring_rd_s1;
	sample_t                  sample_q;
	sample_t                  mean_q;
	logic [DIV_W-1:0]         dnum_q;
	logic [REM_W-1:0]         drem_q;
	logic [DCNT_W-1:0]        dcnt_q;
	logic [CNT_W-1:0]         idx_q;
	logic [MAG_W-1:0]         mag_s2;
	logic [SQ_W-1:0]          sq_s3;
	logic [ACC_W-1:0]         acc_q;
	logic [ROOT_W-1:0]        sres_q;
	logic [ROOT_W-1:0]        sbit_q;
	dev_t                     dev_q;
	logic [SPAN_W-1:0]        span_q;
	logic                     res_acc_q;
	logic                     res_full_q;
	sample_t                  res_mean_q;
	dev_t                     res_dev_q;

	logic                     in_xfer, out_xfer, win_full, issue, var_done;
	logic [IDX_W-1:0]         raddr;
	logic                     ring_we;
	logic [IDX_W-1:0]         waddr;
	logic [REM_W+DIGIT_W-1:0] div_out;
	logic [DIV_W-1:0]         dnum_next;
	logic [REM_W-1:0]         drem_next;
	logic [SUM_W-1:0]         abs_sum;
	logic [SAMPLE_BITS-1:0]   mean_quo;
	sample_t                  mean_val;
	logic signed [MAG_W-1:0]  diff;
	logic [MAG_W-1:0]         mag;
	logic [ROOT_W-1:0]        trial;
	logic                     root_ge;
	logic [ROOT_W-1:0]        sres_next;
	logic signed [BOUND_W-1:0] lo_bound, hi_bound, s_ext;
	logic                     in_range;
	logic [IDX_W-1:0]         oldest_next;

	assign in_xfer  = samples.valid && samples.ready;
	assign out_xfer = results.valid && results.ready;
	assign win_full = (fill_q == CNT_W'(WINDOW_DEPTH));
	assign issue    = (idx_q != CNT_W'(WINDOW_DEPTH));
	assign var_done = !issue && !vld_s1 && !vld_s2 && !vld_s3;

	assign samples.ready            = (state_q == ST_IDLE);
	assign results.valid            = (state_q == ST_OUT);
	assign results.accepted         = res_acc_q;
	assign results.window_was_full  = res_full_q;
	assign results.window_mean      = res_mean_q;
	assign results.window_deviation = res_dev_q;

	assign div_out   = div_digit(drem_q, dnum_q[DIV_W-1 -: DIGIT_W]);
	assign dnum_next = {dnum_q[DIV_W-DIGIT_W-1:0], div_out[DIGIT_W-1:0]};
	assign drem_next = div_out[REM_W+DIGIT_W-1:DIGIT_W];

	assign abs_sum  = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
	assign mean_quo = dnum_next[SAMPLE_BITS-1:0];
	assign mean_val = sum_q[SUM_W-1] ? sample_t'(~mean_quo + 1'b1) : sample_t'(mean_quo);

	assign diff = MAG_W'(ring_rd_s1) - MAG_W'(mean_q);
	assign mag  = diff[MAG_W-1] ? (~diff + 1'b1) : diff;

	assign trial     = sres_q + sbit_q;
	assign root_ge   = dnum_q[ROOT_W-1:0] >= trial;
	assign sres_next = root_ge ? ((sres_q >> 1) + sbit_q) : (sres_q >> 1);

	assign s_ext    = BOUND_W'(sample_q);
	assign lo_bound = BOUND_W'(mean_q) - $signed({2'b00, span_q});
	assign hi_bound = BOUND_W'(mean_q) + $signed({2'b00, span_q});
	assign in_range = !(s_ext < lo_bound || s_ext > hi_bound);

	assign oldest_next = (oldest_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_q + 1'b1;

	assign raddr   = (state_q == ST_VAR && issue) ? idx_q[IDX_W-1:0] : oldest_q;
	assign ring_we = (in_xfer && !win_full) || (state_q == ST_CHECK && in_range);
	assign waddr   = (state_q == ST_CHECK) ? oldest_q : fill_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (ring_we) begin
			sample_ring[waddr] <= (state_q == ST_CHECK) ? sample_q : samples.sample;
		end
		ring_rd_s1 <= sample_ring[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mult_q   <= MULT_RESET;
			fill_q   <= '0;
			oldest_q <= '0;
			sum_q    <= '0;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
		end else begin
			if (cfg_we) begin
				mult_q <= cfg_wdata;
			end
			vld_s1 <= (state_q == ST_VAR) && issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (win_full) begin
							state_q <= ST_MEAN;
						end else begin
							fill_q  <= fill_q + 1'b1;
							sum_q   <= sum_q + SUM_W'(samples.sample);
							state_q <= ST_OUT;
						end
					end
				end
				ST_MEAN: begin
					if (dcnt_q == DCNT_W'(MEAN_DIGITS - 1)) begin
						state_q <= ST_VAR;
					end
				end
				ST_VAR: begin
					if (var_done) begin
						state_q <= ST_VDIV;
					end
				end
				ST_VDIV: begin
					if (dcnt_q == DCNT_W'(DIV_DIGITS - 1)) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sbit_q[0]) begin
						state_q <= ST_SPAN;
					end
				end
				ST_SPAN: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (in_range) begin
						oldest_q <= oldest_next;
						sum_q    <= sum_q + SUM_W'(sample_q) - SUM_W'(ring_rd_s1);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_xfer) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mag_s2 <= mag;
		sq_s3  <= mag_s2 * mag_s2;
		case (state_q)
			ST_IDLE: begin
				sample_q <= samples.sample;
				dnum_q   <= DIV_W'(abs_sum) << MEAN_SHIFT;
				drem_q   <= '0;
				dcnt_q   <= '0;
				if (in_xfer && !win_full) begin
					res_acc_q  <= 1'b1;
					res_full_q <= 1'b0;
					res_mean_q <= '0;
					res_dev_q  <= '0;
				end
			end
			ST_MEAN: begin
				dnum_q <= dnum_next;
				drem_q <= drem_next;
				dcnt_q <= dcnt_q + 1'b1;
				mean_q <= mean_val;
				idx_q  <= '0;
				acc_q  <= '0;
			end
			ST_VAR: begin
				if (issue) begin
					idx_q <= idx_q + 1'b1;
				end
				if (vld_s3) begin
					acc_q <= acc_q + ACC_W'(sq_s3);
				end
				dnum_q <= DIV_W'(acc_q);
				drem_q <= '0;
				dcnt_q <= '0;
			end
			ST_VDIV: begin
				dnum_q <= dnum_next;
				drem_q <= drem_next;
				dcnt_q <= dcnt_q + 1'b1;
				sres_q <= '0;
				sbit_q <= ROOT_W'(1) << (ROOT_W - 2);
			end
			ST_SQRT: begin
				if (root_ge) begin
					dnum_q <= DIV_W'(dnum_q[ROOT_W-1:0] - trial);
				end
				sres_q <= sres_next;
				sbit_q <= sbit_q >> 2;
				dev_q  <= sres_next[DEV_W-1:0];
			end
			ST_SPAN: begin
				span_q <= mult_q * dev_q;
			end
			ST_CHECK: begin
				res_acc_q  <= in_range;
				res_full_q <= 1'b1;
				res_mean_q <= mean_q;
				res_dev_q  <= dev_q;
			end
			default: begin
			end
		endcase
	end

	`SWSOG_ASSERT_IMP(a_fill_range, 1'b1, fill_q <= CNT_W'(WINDOW_DEPTH))
	`SWSOG_ASSERT_IMP(a_oldest_only_full, oldest_q != '0, win_full)
	`SWSOG_ASSERT_IMP(a_one_item, results.valid, !samples.ready)
	`SWSOG_ASSERT_IMP(a_root_bit, state_q == ST_SQRT, $onehot(sbit_q))
	`SWSOG_ASSERT_NXT(a_fill_pass, in_xfer && !win_full, results.valid && results.accepted)

endmodule

`default_nettype wire

>>> bench/testbench.sv
`default_nettype none

module testbench;
	import swsog_pkg::*;

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 600;
	localparam int PHASE_ITEMS = 165;
	localparam int PHASES = 6;
	localparam mult_t PHASE_MULT [PHASES] = '{8'd255, 8'd8, 8'd3, 8'd2, 8'd1, 8'd0};

	typedef struct {
		bit      accepted;
		bit      window_was_full;
		sample_t window_mean;
		dev_t    window_deviation;
	} verdict_t;

	// floor square root, one result bit per pass
	function automatic longint unsigned floor_root(logic [63:0] x);
		logic [31:0] r;
		logic [31:0] t;
		logic [64:0] sq;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (32'd1 << b);
			sq = t * t;
			if (sq <= {1'b0, x})
				r = t;
		end
		return r;
	endfunction

	class outlier_scoreboard;
		sample_t     ring [WINDOW_DEPTH];
		int unsigned fill;
		int unsigned oldest;
		mult_t       mult;
		verdict_t    expected_verdicts [$];
		int          errors;

		function new();
			fill = 0;
			oldest = 0;
			mult = MULT_RESET;
			errors = 0;
		endfunction

		function bit window_full();
			return fill >= WINDOW_DEPTH;
		endfunction

		function bit idle();
			return expected_verdicts.size() == 0;
		endfunction

		function void window_stats(output longint mean, output longint unsigned dev);
			longint      sum;
			longint      diff;
			logic [63:0] mag;
			logic [127:0] acc;
			logic [127:0] quot;
			sum = 0;
			foreach (ring[i])
				sum += longint'(ring[i]);
			mean = sum / WINDOW_DEPTH;
			acc = '0;
			foreach (ring[i]) begin
				diff = longint'(ring[i]) - mean;
				mag = (diff < 0) ? -diff : diff;
				acc += 128'(mag) * 128'(mag);
			end
			quot = acc / 128'(WINDOW_DEPTH);
			dev = floor_root(quot[63:0]);
		endfunction

		function void limits(output longint mean, output longint span);
			longint unsigned dev;
			window_stats(mean, dev);
			span = longint'(mult) * longint'(dev);
		endfunction

		function void note_sample(sample_t s);
			verdict_t v;
			longint   mean;
			longint   span;
			longint unsigned dev;
			v.window_was_full = window_full();
			v.accepted = 1'b1;
			mean = 0;
			dev = 0;
			if (v.window_was_full) begin
				window_stats(mean, dev);
				span = longint'(mult) * longint'(dev);
				if (longint'(s) < mean - span || longint'(s) > mean + span)
					v.accepted = 1'b0;
			end
			if (v.accepted) begin
				if (!v.window_was_full) begin
					ring[fill] = s;
					fill++;
				end else begin
					ring[oldest] = s;
					oldest = (oldest + 1) % WINDOW_DEPTH;
				end
			end
			v.window_mean = sample_t'(mean);
			v.window_deviation = dev_t'(dev);
			expected_verdicts.push_back(v);
		endfunction

		function void check_result(logic acc, logic full, sample_t mean, dev_t dev);
			verdict_t e;
			if (expected_verdicts.size() == 0) begin
				$error("result transfer with no sample outstanding");
				errors++;
				return;
			end
			e = expected_verdicts.pop_front();
			if (acc !== e.accepted) begin
				$error("accepted: expected %0d, got %0d", e.accepted, acc);
				errors++;
			end
			if (full !== e.window_was_full) begin
				$error("window_was_full: expected %0d, got %0d", e.window_was_full, full);
				errors++;
			end
			if (mean !== e.window_mean) begin
				$error("window_mean: expected %0d, got %0d", e.window_mean, mean);
				errors++;
			end
			if (dev !== e.window_deviation) begin
				$error("window_deviation: expected %0d, got %0d", e.window_deviation, dev);
				errors++;
			end
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n;
	logic  cfg_we;
	mult_t cfg_wdata;

	int tx_idle_pct = 8;
	int rx_idle_pct = 52;
	bit rx_hold = 1'b0;
	longint center;

	outlier_scoreboard gate;

	swsog_sample_if samples ();
	swsog_result_if results ();

	sliding_window_sigma_outlier_gate_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.samples   (samples),
		.results   (results)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic sample_t clamp_sample(longint v);
		if (v > longint'(SAMPLE_MAX))
			return SAMPLE_MAX;
		if (v < longint'(SAMPLE_MIN))
			return SAMPLE_MIN;
		return sample_t'(v);
	endfunction

	// samples right at and just past the current acceptance limits
	function automatic sample_t bound_sample(int unsigned which);
		longint mean;
		longint span;
		if (!gate.window_full())
			return sample_t'(center);
		gate.limits(mean, span);
		case (which)
			0: return clamp_sample(mean + span);
			1: return clamp_sample(mean + span + 1);
			2: return clamp_sample(mean - span);
			default: return clamp_sample(mean - span - 1);
		endcase
	endfunction

	function automatic sample_t pick_sample(int unsigned spread);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70)
			return sample_t'(center + longint'($urandom_range(2 * spread)) - longint'(spread));
		if (r < 82)
			return bound_sample($urandom_range(3));
		if (r < 92)
			return sample_t'($urandom);
		case ($urandom_range(3))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return sample_t'(0);
			default: return sample_t'(-1);
		endcase
	endfunction

	task automatic offer(sample_t s);
		while ($urandom_range(99) < tx_idle_pct) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.sample <= s;
		do @(posedge clk); while (!samples.ready);
		gate.note_sample(s);
	endtask

	task automatic drain();
		samples.valid <= 1'b0;
		while (!gate.idle())
			@(posedge clk);
	endtask

	task automatic write_multiplier(mult_t m);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		gate.mult = m;
	endtask

	initial begin
		int unsigned spread;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = MULT_RESET;
		samples.valid = 1'b0;
		samples.sample = '0;
		gate = new();
		center = longint'($signed($urandom)) / 4;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the window, field extremes included, then probe the limits
		offer(SAMPLE_MAX);
		offer(SAMPLE_MIN);
		offer(sample_t'(0));
		offer(sample_t'(-1));
		for (int i = 0; i < WINDOW_DEPTH - 4; i++)
			offer(sample_t'(center + ((i % 2) ? 100 : -100)));
		for (int unsigned k = 0; k < 4; k++)
			offer(bound_sample(k));
		drain();

		for (int p = 0; p < PHASES; p++) begin
			tx_idle_pct = (p < 2) ? 8 : (p < 4) ? 52 : 0;
			rx_idle_pct = (p < 2) ? 52 : (p < 4) ? 8 : 0;
			spread = $urandom_range(1, 4000);
			write_multiplier(PHASE_MULT[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 0 && n == 40)
					rx_hold = 1'b1;
				offer(pick_sample(spread));
			end
			drain();
		end

		repeat (100) @(posedge clk);
		if (gate.errors == 0 && gate.idle())
			$display("sliding_window_sigma_outlier_gate_top regression: pass");
		else
			$display("sliding_window_sigma_outlier_gate_top regression: fail");
		$finish;
	end

	// result side: random stalls plus one long hold-off
	initial begin
		results.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold) begin
				results.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end
			results.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && results.valid && results.ready)
			gate.check_result(results.accepted, results.window_was_full,
				results.window_mean, results.window_deviation);
	end

	// stall watchdog: no transfer on either side for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (samples.valid && samples.ready) || (results.valid && results.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("sliding_window_sigma_outlier_gate_top regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
